// ----- rtl/hkve_pkg.sv -----
package hkve_pkg;

  localparam int unsigned CountWidth   = 17;
  localparam int unsigned SizeWidth    = 16;
  localparam int unsigned ShiftWidth   = 64;
  localparam int unsigned ResultWidth  = 256;
  localparam logic [SizeWidth-1:0] HeaderSizeReset = 16'hFFFF;

  // Lengths of the little-endian captures in bytes.
  localparam logic [3:0] IntLen    = 4'd4;
  localparam logic [3:0] DoubleLen = 4'd8;

  // Characters of the keyword alphabet.
  localparam logic [7:0] ChT   = 8'h74;
  localparam logic [7:0] ChS   = 8'h73;
  localparam logic [7:0] ChA   = 8'h61;
  localparam logic [7:0] ChM   = 8'h6d;
  localparam logic [7:0] ChP   = 8'h70;
  localparam logic [7:0] ChN   = 8'h6e;
  localparam logic [7:0] ChL   = 8'h6c;
  localparam logic [7:0] ChE   = 8'h65;
  localparam logic [7:0] ChF   = 8'h66;
  localparam logic [7:0] ChC   = 8'h63;
  localparam logic [7:0] ChH   = 8'h68;
  localparam logic [7:0] ChOne = 8'h31;
  localparam logic [7:0] ChO   = 8'h6f;

  typedef enum logic [2:0] {
    TGT_NONE     = 3'd0,
    TGT_SAMPLES  = 3'd1,
    TGT_CHANNELS = 3'd2,
    TGT_TIME     = 3'd3,
    TGT_FIRST    = 3'd4,
    TGT_STEP     = 3'd5
  } capture_target_e;

  // Keyword matcher, one-hot. Each state names the prefix seen so far, except M_FOO, which stands for fof.
  typedef enum logic [20:0] {
    M_IDLE    = 21'h000001,
    M_T       = 21'h000002,
    M_TS      = 21'h000004,
    M_TSA     = 21'h000008,
    M_TSAM    = 21'h000010,
    M_N       = 21'h000020,
    M_NS      = 21'h000040,
    M_NSA     = 21'h000080,
    M_NSAM    = 21'h000100,
    M_NSAMP   = 21'h000200,
    M_NSAMPL  = 21'h000400,
    M_NSAMPLE = 21'h000800,
    M_F       = 21'h001000,
    M_FC      = 21'h002000,
    M_FCH     = 21'h004000,
    M_FO      = 21'h008000,
    M_FOO     = 21'h010000,
    M_NC      = 21'h020000,
    M_NCH     = 21'h040000,
    M_NCHA    = 21'h080000,
    M_NCHAN   = 21'h100000
  } match_state_e;

endpackage

// ----- rtl/header_keyword_value_extractor.sv -----
// Header keyword value extractor. Header bytes enter one per beat on the
// slave stream (tlast marks the last byte of the file). A one-hot keyword
// matcher looks for tsamp, nsamples, nchans, fch1 and foff; the last byte of
// a keyword opens a little-endian capture of the next 4 bytes (nsamples,
// nchans) or 8 bytes (tsamp, fch1, foff, kept as raw double bit patterns).
// Every byte counts toward the header length. After a byte that neither
// belongs to nor opens a capture, or after the last byte of a capture, the
// count is compared with header_size; when it has been reached, or at tlast,
// one result beat carries the five values (zero for any keyword not seen)
// and the parser returns to its reset state. A capture cut short by tlast is
// dropped. The block takes one byte every cycle, also while a result waits,
// as long as the result register is free or being emptied in that cycle:
// each byte goes through the matcher and capture logic combinationally,
// straight into the state and result registers. The user must write
// header_size on the configuration channel only while the stream is idle;
// the block does not enforce this. header_size resets to 65535.
module header_keyword_value_extractor
  import hkve_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration: header_size.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [SizeWidth-1:0]   cfg_data_i,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
  input  logic                   s_axis_tlast,  // stream_end
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] nr_samples, [63:32] nr_channels, [127:64] sample_time_bits,
  // [191:128] first_freq_bits, [255:192] freq_step_bits
  output logic [ResultWidth-1:0] m_axis_tdata
);

  logic [SizeWidth-1:0]   header_size_q;
  match_state_e           match_q, match_d;
  logic [CountWidth-1:0]  count_q, count_d;
  logic [3:0]             left_q, left_d;
  capture_target_e        target_q, target_d;
  logic [ShiftWidth-1:0]  shift_q, shift_d;
  logic [31:0]            samples_q, samples_d;
  logic [31:0]            channels_q, channels_d;
  logic [63:0]            time_q, time_d;
  logic [63:0]            first_q, first_d;
  logic [63:0]            step_q, step_d;
  logic                   out_valid_q;
  logic [ResultWidth-1:0] out_data_q;

  logic in_fire;
  logic emit;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Next state for one accepted byte.
  always_comb begin
    logic [3:0] len;
    logic [2:0] pos;
    logic       check;
    logic       start;
    capture_target_e start_tgt;
    logic [3:0] start_len;

    match_d    = match_q;
    left_d     = left_q;
    target_d   = target_q;
    shift_d    = shift_q;
    samples_d  = samples_q;
    channels_d = channels_q;
    time_d     = time_q;
    first_d    = first_q;
    step_d     = step_q;
    count_d    = count_q + CountWidth'(1);
    check      = 1'b0;
    start      = 1'b0;
    start_tgt  = TGT_NONE;
    start_len  = 4'd0;
    len = (target_q == TGT_SAMPLES || target_q == TGT_CHANNELS) ? IntLen : DoubleLen;
    pos = 3'(len - left_q);

    if (left_q != 4'd0) begin
      // Capture byte: place it at its little-endian position.
      for (int i = 0; i < 8; i++) begin
        if (pos == 3'(i)) begin
          shift_d[i*8 +: 8] = s_axis_tdata;
        end
      end
      left_d = left_q - 4'd1;
      if (left_q == 4'd1) begin
        case (target_q)
          TGT_SAMPLES:  samples_d  = shift_d[31:0];
          TGT_CHANNELS: channels_d = shift_d[31:0];
          TGT_TIME:     time_d     = shift_d;
          TGT_FIRST:    first_d    = shift_d;
          TGT_STEP:     step_d     = shift_d;
          default: ;
        endcase
        target_d = TGT_NONE;
        shift_d  = '0;
        check    = 1'b1;
      end
    end else begin
      // Keyword matcher. Characters outside the alphabet leave it alone.
      case (s_axis_tdata)
        ChT: begin
          if (match_q == M_IDLE) match_d = M_T;
        end
        ChS: begin
          if (match_q == M_T) match_d = M_TS;
          else if (match_q == M_N) match_d = M_NS;
          else if (match_q == M_NSAMPLE) begin
            start = 1'b1; start_tgt = TGT_SAMPLES; start_len = IntLen;
          end else if (match_q == M_NCHAN) begin
            start = 1'b1; start_tgt = TGT_CHANNELS; start_len = IntLen;
          end else match_d = M_IDLE;
        end
        ChA: begin
          if (match_q == M_TS) match_d = M_TSA;
          else if (match_q == M_NS) match_d = M_NSA;
          else if (match_q == M_NCH) match_d = M_NCHA;
          else match_d = M_IDLE;
        end
        ChM: begin
          if (match_q == M_TSA) match_d = M_TSAM;
          else if (match_q == M_NSA) match_d = M_NSAM;
          else match_d = M_IDLE;
        end
        ChP: begin
          if (match_q == M_TSAM) begin
            start = 1'b1; start_tgt = TGT_TIME; start_len = DoubleLen;
          end else if (match_q == M_NSAM) match_d = M_NSAMP;
          else match_d = M_IDLE;
        end
        ChN: begin
          if (match_q == M_IDLE) match_d = M_N;
          else if (match_q == M_NCHA) match_d = M_NCHAN;
          else match_d = M_IDLE;
        end
        ChL: match_d = (match_q == M_NSAMP) ? M_NSAMPL : M_IDLE;
        ChE: match_d = (match_q == M_NSAMPL) ? M_NSAMPLE : M_IDLE;
        ChF: begin
          if (match_q == M_IDLE) match_d = M_F;
          else if (match_q == M_FO) match_d = M_FOO;
          else if (match_q == M_FOO) begin
            start = 1'b1; start_tgt = TGT_STEP; start_len = DoubleLen;
          end else match_d = M_IDLE;
        end
        ChC: begin
          if (match_q == M_F) match_d = M_FC;
          else if (match_q == M_N) match_d = M_NC;
          else match_d = M_IDLE;
        end
        ChH: begin
          if (match_q == M_FC) match_d = M_FCH;
          else if (match_q == M_NC) match_d = M_NCH;
          else match_d = M_IDLE;
        end
        ChOne: begin
          if (match_q == M_FCH) begin
            start = 1'b1; start_tgt = TGT_FIRST; start_len = DoubleLen;
          end else match_d = M_IDLE;
        end
        ChO: match_d = (match_q == M_F) ? M_FO : M_IDLE;
        default: ;
      endcase
      if (start) begin
        match_d  = M_IDLE;
        target_d = start_tgt;
        left_d   = start_len;
        shift_d  = '0;
      end
      check = !start;
    end

    emit = (check && (count_d >= {1'b0, header_size_q})) || s_axis_tlast;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_size_q <= HeaderSizeReset;
      match_q       <= M_IDLE;
      count_q       <= '0;
      left_q        <= '0;
      target_q      <= TGT_NONE;
      shift_q       <= '0;
      samples_q     <= '0;
      channels_q    <= '0;
      time_q        <= '0;
      first_q       <= '0;
      step_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        header_size_q <= cfg_data_i;
      end
      if (in_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        if (emit) begin
          match_q    <= M_IDLE;
          count_q    <= '0;
          left_q     <= '0;
          target_q   <= TGT_NONE;
          shift_q    <= '0;
          samples_q  <= '0;
          channels_q <= '0;
          time_q     <= '0;
          first_q    <= '0;
          step_q     <= '0;
        end else begin
          match_q    <= match_d;
          count_q    <= count_d;
          left_q     <= left_d;
          target_q   <= target_d;
          shift_q    <= shift_d;
          samples_q  <= samples_d;
          channels_q <= channels_d;
          time_q     <= time_d;
          first_q    <= first_d;
          step_q     <= step_d;
        end
      end
    end
  end

  // Result payload, loaded only when a result is produced.
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_data_q <= {step_d, first_d, time_d, channels_d, samples_d};
    end
  end

endmodule

// ----- rtl/hkve_checker.sv -----
module hkve_port_checker
  import hkve_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [ResultWidth-1:0] m_axis_tdata
);

  // No result beat is shown while reset is held.
  assert property (@(posedge clk_i) !rst_ni ##1 !rst_ni |-> !m_axis_tvalid)
    else $error("result beat valid during reset");

  // A stalled result beat stays and keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // The last byte of a file always yields a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("no result after last byte");

  // Input is only held back while a result beat is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

bind header_keyword_value_extractor hkve_port_checker u_hkve_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
